// File: design/jad_pkg.sv
// Shared constants, payload types and unit widths for the jump airtime detector.
package jad_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_FALL_THR       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUND_THR     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIRM_MS     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_AIRTIME_MIN_MS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_AIRTIME_MAX_MS = 3'd4;

   localparam logic [11:0] FALL_THR_RESET       = 12'd350;
   localparam logic [11:0] GROUND_THR_RESET     = 12'd700;
   localparam logic [9:0]  CONFIRM_MS_RESET     = 10'd50;
   localparam logic [11:0] AIRTIME_MIN_MS_RESET = 12'd120;
   localparam logic [11:0] AIRTIME_MAX_MS_RESET = 12'd2000;

   // Event codes
   localparam logic [1:0] EVENT_NONE    = 2'd0;
   localparam logic [1:0] EVENT_TAKEOFF = 2'd1;
   localparam logic [1:0] EVENT_LANDED  = 2'd2;
   localparam logic [1:0] EVENT_ABORTED = 2'd3;

   localparam logic [11:0] AIRTIME_SAT = 12'hFFF;

   // Bit-serial multiplier: multiplicand x multiplier, one multiplier bit per cycle
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 13;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Bit-serial restoring divider: one quotient bit per cycle
   localparam int DIV_N_W = 35;
   localparam int DIV_D_W = 20;
   localparam int DIV_Q_W = 15;

   // Squared axis magnitude in mg^2
   localparam int LANE_SQ_W = 22;

   localparam logic [DIV_D_W-1:0] MG_DIVISOR     = 20'd1000;
   localparam logic [DIV_D_W-1:0] HEIGHT_DIVISOR = 20'd800000;
   localparam logic [MUL_B_W-1:0] HEIGHT_SCALE   = 13'd981;
   localparam logic [DIV_N_W-1:0] HEIGHT_ROUND   = 35'd400000;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [31:0]        now_ms;
   } req_payload_type;

   typedef struct packed {
      logic        in_air;
      logic [1:0]  event_res;
      logic [11:0] airtime_ms;
      logic [14:0] height_tenths_cm;
   } rsp_payload_type;

endpackage

// File: design/jad_stream_if.sv
// Valid/ready stream channel carrying one payload struct per beat.
interface jad_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: design/jad_serial_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module jad_serial_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [jad_pkg::MUL_A_W-1:0]  mcand,
   input  logic [jad_pkg::MUL_B_W-1:0]  mplier,
   output logic                         done,
   output logic [jad_pkg::MUL_P_W-1:0]  product
);
   import jad_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MUL_P_W-1:0] mcand_ff, mcand_in;
   logic [MUL_P_W-1:0] acc_ff, acc_in;
   logic [MUL_B_W-1:0] mplier_ff, mplier_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mcand_in  = MUL_P_W'(mcand);
         mplier_in = mplier;
         acc_in    = '0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: design/jad_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module jad_serial_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [jad_pkg::DIV_N_W-1:0]  num,
   input  logic [jad_pkg::DIV_D_W-1:0]  divisor,
   output logic                         done,
   output logic [jad_pkg::DIV_Q_W-1:0]  quotient
);
   import jad_pkg::*;

   localparam int CNT_W = $clog2(DIV_Q_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_Q_W-1:0] low_ff, low_in;
   logic [DIV_Q_W-1:0] quo_ff, quo_in;
   logic [DIV_D_W:0]   trial;
   logic [DIV_D_W:0]   diff;
   logic               fits;

   // Remainder stays below the divisor, so the trial value never needs more bits
   assign trial = {rem_ff, low_ff[DIV_Q_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num[DIV_N_W-1:DIV_Q_W];
         low_in  = num[DIV_Q_W-1:0];
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         low_in = low_ff << 1;
         quo_in = {quo_ff[DIV_Q_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: design/jad_axis_lane.sv
// One axis: scale raw counts to mg, then square, both bit-serial.
module jad_axis_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [15:0]             raw,
   output logic                           done,
   output logic [jad_pkg::LANE_SQ_W-1:0]  square
);
   import jad_pkg::*;

   logic [15:0]        raw_u;
   logic [15:0]        mag;
   logic [20:0]        mag_w;
   logic [20:0]        scaled;
   logic               div_done;
   logic [DIV_Q_W-1:0] mg;
   logic [MUL_P_W-1:0] prod;

   // Truncation toward zero: divide the magnitude, the sign drops out when squared
   assign raw_u  = raw;
   assign mag    = raw_u[15] ? 16'(~raw_u + 16'd1) : raw_u;
   assign mag_w  = 21'(mag);
   assign scaled = (mag_w << 6) - (mag_w << 2) + mag_w;

   jad_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .num      (DIV_N_W'(scaled)),
      .divisor  (MG_DIVISOR),
      .done     (div_done),
      .quotient (mg)
   );

   jad_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (div_done),
      .mcand   (MUL_A_W'(mg)),
      .mplier  (mg[MUL_B_W-1:0]),
      .done    (done),
      .product (prod)
   );

   assign square = prod[LANE_SQ_W-1:0];

endmodule

// File: design/jad_height_unit.sv
// Jump height round(981 * t^2 / 800000) by serial square, scale and divide.
module jad_height_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [11:0]                  air,
   output logic                         done,
   output logic [jad_pkg::DIV_Q_W-1:0]  height
);
   import jad_pkg::*;

   typedef enum logic [1:0] {
      H_IDLE,
      H_SQUARE,
      H_SCALE,
      H_DIVIDE
   } state_type;

   state_type          state_ff, state_in;
   logic               mul_start;
   logic [MUL_A_W-1:0] mul_mcand;
   logic [MUL_B_W-1:0] mul_mplier;
   logic               mul_done;
   logic [MUL_P_W-1:0] product;
   logic               div_start;
   logic               div_done;

   always_comb begin
      state_in   = state_ff;
      mul_start  = 1'b0;
      mul_mcand  = MUL_A_W'(air);
      mul_mplier = MUL_B_W'(air);
      div_start  = 1'b0;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               mul_start = 1'b1;
               state_in  = H_SQUARE;
            end
         end
         H_SQUARE: begin
            // Reuse the multiplier: t^2 times the scale factor
            mul_mcand  = product[MUL_A_W-1:0];
            mul_mplier = HEIGHT_SCALE;
            if (mul_done) begin
               mul_start = 1'b1;
               state_in  = H_SCALE;
            end
         end
         H_SCALE: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = H_DIVIDE;
            end
         end
         H_DIVIDE: begin
            if (div_done) begin
               state_in = H_IDLE;
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   jad_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (product)
   );

   jad_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (product[DIV_N_W-1:0] + HEIGHT_ROUND),
      .divisor  (HEIGHT_DIVISOR),
      .done     (div_done),
      .quotient (height)
   );

   assign done = (state_ff == H_DIVIDE) && div_done;

endmodule

// File: design/jump_airtime_detector.sv
// Jump airtime detector: debounced low-g takeoff and high-g landing from 3-axis samples.
// Each sample passes the bit-serial divide and square in each axis lane and, on an
//   accepted landing, the serial height unit; a new sample is taken only after the
//   result of the last one has gone into the output register.
// Reset: synchronous, active high; thresholds take their defaults, phase goes idle,
//   debounce state clears and the result register empties.
module jump_airtime_detector (
   input  logic                            clock,
   input  logic                            reset,
   jad_stream_if.sink                      req_chan,
   jad_stream_if.source                    rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [jad_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [jad_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import jad_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQUARE,
      S_SUM_XY,
      S_SUM_Z,
      S_DEBOUNCE,
      S_DIFF,
      S_DECIDE,
      S_HEIGHT,
      S_OUTPUT
   } state_type;

   function automatic logic [11:0] sat_airtime(input logic [31:0] t);
      sat_airtime = (t > 32'(AIRTIME_SAT)) ? AIRTIME_SAT : t[11:0];
   endfunction

   state_type          state_ff, state_in;

   logic [11:0]        freefall_ff, freefall_in;
   logic [11:0]        landed_ff, landed_in;
   logic [9:0]         confirm_ff, confirm_in;
   logic [11:0]        air_min_ff, air_min_in;
   logic [11:0]        air_max_ff, air_max_in;

   logic signed [15:0] raw_x_ff, raw_x_in;
   logic signed [15:0] raw_y_ff, raw_y_in;
   logic signed [15:0] raw_z_ff, raw_z_in;
   logic [31:0]        now_ff, now_in;
   logic               lane_start_ff, lane_start_in;

   logic [23:0]        sum_ff, sum_in;

   logic               phase_ff, phase_in;
   logic               low_valid_ff, low_valid_in;
   logic [31:0]        low_start_ff, low_start_in;
   logic               high_valid_ff, high_valid_in;
   logic [31:0]        high_start_ff, high_start_in;
   logic [31:0]        takeoff_ff, takeoff_in;

   logic [31:0]        d_low_ff, d_low_in;
   logic [31:0]        d_high_ff, d_high_in;
   logic [31:0]        elapsed_ff, elapsed_in;
   logic [31:0]        air_ff, air_in;

   logic [1:0]         out_event_ff, out_event_in;
   logic [11:0]        out_airtime_ff, out_airtime_in;
   logic [14:0]        out_height_ff, out_height_in;
   logic               height_start_ff, height_start_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   logic                 lane_done_x, lane_done_y, lane_done_z;
   logic [LANE_SQ_W-1:0] sq_x, sq_y, sq_z;
   logic [12:0]          landed_p1;
   logic [MUL_P_W-1:0]   lo_prod, hi_prod;
   logic                 below, above;
   logic                 height_done;
   logic [DIV_Q_W-1:0]   height;

   assign landed_p1 = 13'(landed_ff) + 13'd1;
   assign below     = 25'(sum_ff) <  lo_prod[24:0];
   assign above     = 25'(sum_ff) >= hi_prod[24:0];

   always_comb begin
      state_in        = state_ff;
      freefall_in     = freefall_ff;
      landed_in       = landed_ff;
      confirm_in      = confirm_ff;
      air_min_in      = air_min_ff;
      air_max_in      = air_max_ff;
      raw_x_in        = raw_x_ff;
      raw_y_in        = raw_y_ff;
      raw_z_in        = raw_z_ff;
      now_in          = now_ff;
      lane_start_in   = 1'b0;
      sum_in          = sum_ff;
      phase_in        = phase_ff;
      low_valid_in    = low_valid_ff;
      low_start_in    = low_start_ff;
      high_valid_in   = high_valid_ff;
      high_start_in   = high_start_ff;
      takeoff_in      = takeoff_ff;
      d_low_in        = d_low_ff;
      d_high_in       = d_high_ff;
      elapsed_in      = elapsed_ff;
      air_in          = air_ff;
      out_event_in    = out_event_ff;
      out_airtime_in  = out_airtime_ff;
      out_height_in   = out_height_ff;
      height_start_in = 1'b0;
      rsp_valid_in    = rsp_valid_ff & ~rsp_chan.ready;
      rsp_payload_in  = rsp_payload_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_FALL_THR:       freefall_in = csr_wdata[11:0];
            CSR_GROUND_THR:     landed_in   = csr_wdata[11:0];
            CSR_CONFIRM_MS:     confirm_in  = csr_wdata[9:0];
            CSR_AIRTIME_MIN_MS: air_min_in  = csr_wdata[11:0];
            CSR_AIRTIME_MAX_MS: air_max_in  = csr_wdata[11:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               raw_x_in      = req_chan.payload.accel_x;
               raw_y_in      = req_chan.payload.accel_y;
               raw_z_in      = req_chan.payload.accel_z;
               now_in        = req_chan.payload.now_ms;
               lane_start_in = 1'b1;
               state_in      = S_SQUARE;
            end
         end
         S_SQUARE: begin
            // Lanes run in lockstep; thresholds finish earlier and hold
            if (lane_done_x && lane_done_y && lane_done_z) begin
               state_in = S_SUM_XY;
            end
         end
         S_SUM_XY: begin
            sum_in   = 24'(sq_x) + 24'(sq_y);
            state_in = S_SUM_Z;
         end
         S_SUM_Z: begin
            sum_in   = sum_ff + 24'(sq_z);
            state_in = S_DEBOUNCE;
         end
         S_DEBOUNCE: begin
            if (below) begin
               if (!low_valid_ff) begin
                  low_valid_in = 1'b1;
                  low_start_in = now_ff;
               end
            end else begin
               low_valid_in = 1'b0;
            end
            if (above) begin
               if (!high_valid_ff) begin
                  high_valid_in = 1'b1;
                  high_start_in = now_ff;
               end
            end else begin
               high_valid_in = 1'b0;
            end
            state_in = S_DIFF;
         end
         S_DIFF: begin
            d_low_in   = now_ff - low_start_ff;
            d_high_in  = now_ff - high_start_ff;
            elapsed_in = now_ff - takeoff_ff;
            air_in     = high_start_ff - takeoff_ff;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            out_event_in   = EVENT_NONE;
            out_airtime_in = '0;
            out_height_in  = '0;
            state_in       = S_OUTPUT;
            if (!phase_ff) begin
               if (low_valid_ff && (d_low_ff >= 32'(confirm_ff))) begin
                  takeoff_in     = low_start_ff;
                  phase_in       = 1'b1;
                  out_event_in   = EVENT_TAKEOFF;
                  out_airtime_in = sat_airtime(d_low_ff);
               end
            end else begin
               if (high_valid_ff && (d_high_ff >= 32'(confirm_ff))
                   && (air_ff >= 32'(air_min_ff))) begin
                  phase_in = 1'b0;
                  if (air_ff <= 32'(air_max_ff)) begin
                     out_event_in    = EVENT_LANDED;
                     out_airtime_in  = air_ff[11:0];
                     height_start_in = 1'b1;
                     state_in        = S_HEIGHT;
                  end else begin
                     out_event_in = EVENT_ABORTED;
                  end
               end else if (elapsed_ff > 32'(air_max_ff)) begin
                  phase_in     = 1'b0;
                  out_event_in = EVENT_ABORTED;
               end else begin
                  out_airtime_in = sat_airtime(elapsed_ff);
               end
            end
         end
         S_HEIGHT: begin
            if (height_done) begin
               out_height_in = height;
               state_in      = S_OUTPUT;
            end
         end
         S_OUTPUT: begin
            // Hold the result until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in                    = 1'b1;
               rsp_payload_in.in_air           = phase_ff;
               rsp_payload_in.event_res        = out_event_ff;
               rsp_payload_in.airtime_ms       = out_airtime_ff;
               rsp_payload_in.height_tenths_cm = out_height_ff;
               state_in                        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         freefall_ff     <= FALL_THR_RESET;
         landed_ff       <= GROUND_THR_RESET;
         confirm_ff      <= CONFIRM_MS_RESET;
         air_min_ff      <= AIRTIME_MIN_MS_RESET;
         air_max_ff      <= AIRTIME_MAX_MS_RESET;
         lane_start_ff   <= 1'b0;
         phase_ff        <= 1'b0;
         low_valid_ff    <= 1'b0;
         low_start_ff    <= '0;
         high_valid_ff   <= 1'b0;
         high_start_ff   <= '0;
         takeoff_ff      <= '0;
         height_start_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         freefall_ff     <= freefall_in;
         landed_ff       <= landed_in;
         confirm_ff      <= confirm_in;
         air_min_ff      <= air_min_in;
         air_max_ff      <= air_max_in;
         lane_start_ff   <= lane_start_in;
         phase_ff        <= phase_in;
         low_valid_ff    <= low_valid_in;
         low_start_ff    <= low_start_in;
         high_valid_ff   <= high_valid_in;
         high_start_ff   <= high_start_in;
         takeoff_ff      <= takeoff_in;
         height_start_ff <= height_start_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      raw_x_ff       <= raw_x_in;
      raw_y_ff       <= raw_y_in;
      raw_z_ff       <= raw_z_in;
      now_ff         <= now_in;
      sum_ff         <= sum_in;
      d_low_ff       <= d_low_in;
      d_high_ff      <= d_high_in;
      elapsed_ff     <= elapsed_in;
      air_ff         <= air_in;
      out_event_ff   <= out_event_in;
      out_airtime_ff <= out_airtime_in;
      out_height_ff  <= out_height_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   jad_axis_lane u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .start  (lane_start_ff),
      .raw    (raw_x_ff),
      .done   (lane_done_x),
      .square (sq_x)
   );

   jad_axis_lane u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .start  (lane_start_ff),
      .raw    (raw_y_ff),
      .done   (lane_done_y),
      .square (sq_y)
   );

   jad_axis_lane u_lane_z (
      .clock  (clock),
      .reset  (reset),
      .start  (lane_start_ff),
      .raw    (raw_z_ff),
      .done   (lane_done_z),
      .square (sq_z)
   );

   // Squared thresholds: below the fall threshold squared is weightless,
   // at or above (ground threshold + 1) squared is back on ground
   jad_serial_mul u_lo_thr (
      .clock   (clock),
      .reset   (reset),
      .start   (lane_start_ff),
      .mcand   (MUL_A_W'(freefall_ff)),
      .mplier  (MUL_B_W'(freefall_ff)),
      .done    (),
      .product (lo_prod)
   );

   jad_serial_mul u_hi_thr (
      .clock   (clock),
      .reset   (reset),
      .start   (lane_start_ff),
      .mcand   (MUL_A_W'(landed_p1)),
      .mplier  (landed_p1),
      .done    (),
      .product (hi_prod)
   );

   jad_height_unit u_height (
      .clock  (clock),
      .reset  (reset),
      .start  (height_start_ff),
      .air    (out_airtime_ff),
      .done   (height_done),
      .height (height)
   );

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule
